[hw/rtl/distance_moving_average_derivs_assert.svh]
`ifndef DISTANCE_MOVING_AVERAGE_DERIVS_ASSERT_SVH
`define DISTANCE_MOVING_AVERAGE_DERIVS_ASSERT_SVH

// same-cycle implication, checked outside reset
`define DMAD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define DMAD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/dmad_pkg.sv]
package dmad_pkg;

	localparam int HISTORY_DEPTH_DEF = 8;
	localparam int SENSOR_COUNT_DEF  = 3;

	localparam int SAMPLE_W = 16;
	localparam int SEL_W    = 2;
	localparam int SLOPE_W  = 17;
	localparam int CURV_W   = 18;

	localparam logic [SAMPLE_W-1:0] CEILING_RESET = 16'd4000;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DIFF,
		ST_UPD,
		ST_ABS,
		ST_MUL,
		ST_BACK,
		ST_FIX,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		LINE_LEVEL,
		LINE_SLOPE,
		LINE_CURV
	} line_t;

	typedef struct packed {
		logic  clear_step;
		logic  capture;
		logic  diff;
		logic  update;
		logic  div_abs;
		logic  div_mul;
		logic  div_back;
		logic  div_fix;
		line_t line;
		logic  load_out;
	} cmd_t;

	typedef struct packed {
		logic clear_last;
		logic sel_ok;
	} status_t;

endpackage

[hw/rtl/dmad_ctrl.sv]
module dmad_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              out_ready,
	input  dmad_pkg::status_t status,
	output logic              in_ready,
	output logic              out_valid,
	output dmad_pkg::cmd_t    cmd
);

	dmad_pkg::state_t state_q, state_d;
	dmad_pkg::line_t  line_q, line_d;
	logic             out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= dmad_pkg::ST_CLEAR;
			line_q      <= dmad_pkg::LINE_LEVEL;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			line_q  <= line_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		line_d  = line_q;
		unique case (state_q)
			dmad_pkg::ST_CLEAR: begin
				if (status.clear_last) state_d = dmad_pkg::ST_IDLE;
			end
			dmad_pkg::ST_IDLE: begin
				line_d = dmad_pkg::LINE_LEVEL;
				if (in_valid) state_d = dmad_pkg::ST_DIFF;
			end
			dmad_pkg::ST_DIFF: begin
				state_d = status.sel_ok ? dmad_pkg::ST_UPD : dmad_pkg::ST_DONE;
			end
			dmad_pkg::ST_UPD:  state_d = dmad_pkg::ST_ABS;
			dmad_pkg::ST_ABS:  state_d = dmad_pkg::ST_MUL;
			dmad_pkg::ST_MUL:  state_d = dmad_pkg::ST_BACK;
			dmad_pkg::ST_BACK: state_d = dmad_pkg::ST_FIX;
			dmad_pkg::ST_FIX: begin
				unique case (line_q)
					dmad_pkg::LINE_LEVEL: begin
						line_d  = dmad_pkg::LINE_SLOPE;
						state_d = dmad_pkg::ST_ABS;
					end
					dmad_pkg::LINE_SLOPE: begin
						line_d  = dmad_pkg::LINE_CURV;
						state_d = dmad_pkg::ST_ABS;
					end
					default: state_d = dmad_pkg::ST_DONE;
				endcase
			end
			dmad_pkg::ST_DONE: begin
				if (!out_valid_q || out_ready) state_d = dmad_pkg::ST_IDLE;
			end
			default: state_d = dmad_pkg::ST_CLEAR;
		endcase
	end

	always_comb begin
		cmd      = '0;
		cmd.line = line_q;
		in_ready = 1'b0;
		unique case (state_q)
			dmad_pkg::ST_CLEAR: cmd.clear_step = 1'b1;
			dmad_pkg::ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			dmad_pkg::ST_DIFF: cmd.diff     = status.sel_ok;
			dmad_pkg::ST_UPD:  cmd.update   = 1'b1;
			dmad_pkg::ST_ABS:  cmd.div_abs  = 1'b1;
			dmad_pkg::ST_MUL:  cmd.div_mul  = 1'b1;
			dmad_pkg::ST_BACK: cmd.div_back = 1'b1;
			dmad_pkg::ST_FIX:  cmd.div_fix  = 1'b1;
			dmad_pkg::ST_DONE: cmd.load_out = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

[hw/rtl/dmad_dp.sv]
module dmad_dp #(
	parameter int HISTORY_DEPTH = dmad_pkg::HISTORY_DEPTH_DEF,
	parameter int SENSOR_COUNT  = dmad_pkg::SENSOR_COUNT_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  dmad_pkg::cmd_t                      cmd,
	input  logic                                cfg_we,
	input  logic        [dmad_pkg::SAMPLE_W-1:0] cfg_data,
	input  logic        [dmad_pkg::SAMPLE_W-1:0] distance_sample,
	input  logic        [dmad_pkg::SEL_W-1:0]    sensor_select,
	output dmad_pkg::status_t                   status,
	output logic        [dmad_pkg::SEL_W-1:0]    sensor_echo,
	output logic        [dmad_pkg::SAMPLE_W-1:0] newest_level,
	output logic        [dmad_pkg::SAMPLE_W-1:0] mean_level,
	output logic signed [dmad_pkg::SLOPE_W-1:0]  mean_slope,
	output logic signed [dmad_pkg::CURV_W-1:0]   mean_curvature
);

	localparam int SW       = dmad_pkg::SAMPLE_W;
	localparam int LW       = dmad_pkg::SLOPE_W;
	localparam int CW       = dmad_pkg::CURV_W;
	localparam int MEM_D    = SENSOR_COUNT * HISTORY_DEPTH;
	localparam int ADDR_W   = $clog2(MEM_D);
	localparam int PTR_W    = $clog2(HISTORY_DEPTH);
	localparam int SIDX_W   = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;
	localparam int SUM_W    = CW + $clog2(HISTORY_DEPTH);
	localparam logic [SUM_W-1:0] DEPTH_V = SUM_W'(HISTORY_DEPTH);
	localparam logic [SUM_W-1:0] RECIP   = SUM_W'((64'd1 << SUM_W) / HISTORY_DEPTH);
	localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(MEM_D - 1);
	localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(HISTORY_DEPTH - 1);

	logic        [SW-1:0]     mem_lvl [MEM_D];
	logic signed [LW-1:0]     mem_slp [MEM_D];
	logic signed [CW-1:0]     mem_crv [MEM_D];

	logic        [SW-1:0]     ceiling_q;
	logic        [ADDR_W-1:0] clr_cnt_q;
	logic        [PTR_W-1:0]  ptr_q        [SENSOR_COUNT];
	logic        [SW-1:0]     newest_lvl_q [SENSOR_COUNT];
	logic signed [LW-1:0]     newest_slp_q [SENSOR_COUNT];
	logic signed [SUM_W-1:0]  sum_lvl_q    [SENSOR_COUNT];
	logic signed [SUM_W-1:0]  sum_slp_q    [SENSOR_COUNT];
	logic signed [SUM_W-1:0]  sum_crv_q    [SENSOR_COUNT];

	logic        [SW-1:0]       sample_q;
	logic        [dmad_pkg::SEL_W-1:0] sel_q;
	logic        [SW-1:0]       lvl_new_q, rd_lvl_q;
	logic signed [LW-1:0]       slp_new_q, rd_slp_q;
	logic signed [CW-1:0]       crv_new_q, rd_crv_q;
	logic        [SUM_W-1:0]    mag_q, q0_q, qd_q;
	logic                       neg_q;
	logic        [2*SUM_W-1:0]  prod_q;
	logic        [SW-1:0]       mean_lvl_q;
	logic signed [LW-1:0]       mean_slp_q;
	logic signed [CW-1:0]       mean_crv_q;
	logic        [dmad_pkg::SEL_W-1:0] echo_q;
	logic        [SW-1:0]       out_lvl_q, out_mlvl_q;
	logic signed [LW-1:0]       out_mslp_q;
	logic signed [CW-1:0]       out_mcrv_q;

	logic        [SIDX_W-1:0] sidx;
	logic        [ADDR_W-1:0] addr;
	logic        [SW-1:0]     level;
	logic signed [LW-1:0]     slope;
	logic signed [CW-1:0]     curv;
	logic signed [SUM_W-1:0]  sum_pick;
	logic        [SUM_W-1:0]  q0, rem, quot, res;

	assign sidx  = SIDX_W'(sel_q);
	assign addr  = ADDR_W'(32'(sidx) * HISTORY_DEPTH) + ADDR_W'(ptr_q[sidx]);
	assign level = (sample_q < ceiling_q) ? sample_q : ceiling_q;
	assign slope = $signed({1'b0, level}) - $signed({1'b0, newest_lvl_q[sidx]});
	assign curv  = CW'(slope) - CW'(newest_slp_q[sidx]);

	always_comb begin
		case (cmd.line)
			dmad_pkg::LINE_SLOPE: sum_pick = sum_slp_q[sidx];
			dmad_pkg::LINE_CURV:  sum_pick = sum_crv_q[sidx];
			default:              sum_pick = sum_lvl_q[sidx];
		endcase
	end

	assign q0   = prod_q[2*SUM_W-1:SUM_W];
	assign rem  = mag_q - qd_q;
	assign quot = q0_q + SUM_W'(rem >= DEPTH_V);
	assign res  = neg_q ? (SUM_W'(0) - quot) : quot;

	assign status.clear_last = (clr_cnt_q == CLR_LAST);
	assign status.sel_ok     = (32'(sel_q) < SENSOR_COUNT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ceiling_q <= dmad_pkg::CEILING_RESET;
			clr_cnt_q <= '0;
			for (int s = 0; s < SENSOR_COUNT; s++) begin
				ptr_q[s]        <= '0;
				newest_lvl_q[s] <= '0;
				newest_slp_q[s] <= '0;
				sum_lvl_q[s]    <= '0;
				sum_slp_q[s]    <= '0;
				sum_crv_q[s]    <= '0;
			end
		end else begin
			if (cfg_we) ceiling_q <= cfg_data;
			if (cmd.clear_step && !status.clear_last) clr_cnt_q <= clr_cnt_q + 1'b1;
			if (cmd.update) begin
				ptr_q[sidx]        <= (ptr_q[sidx] == PTR_LAST) ? '0 : ptr_q[sidx] + 1'b1;
				newest_lvl_q[sidx] <= lvl_new_q;
				newest_slp_q[sidx] <= slp_new_q;
				sum_lvl_q[sidx]    <= sum_lvl_q[sidx] + SUM_W'($signed({1'b0, lvl_new_q}))
				                      - SUM_W'($signed({1'b0, rd_lvl_q}));
				sum_slp_q[sidx]    <= sum_slp_q[sidx] + SUM_W'(slp_new_q) - SUM_W'(rd_slp_q);
				sum_crv_q[sidx]    <= sum_crv_q[sidx] + SUM_W'(crv_new_q) - SUM_W'(rd_crv_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clear_step) begin
			mem_lvl[clr_cnt_q] <= '0;
			mem_slp[clr_cnt_q] <= '0;
			mem_crv[clr_cnt_q] <= '0;
		end else if (cmd.update) begin
			mem_lvl[addr] <= lvl_new_q;
			mem_slp[addr] <= slp_new_q;
			mem_crv[addr] <= crv_new_q;
		end
		if (cmd.diff) begin
			rd_lvl_q <= mem_lvl[addr];
			rd_slp_q <= mem_slp[addr];
			rd_crv_q <= mem_crv[addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			sample_q <= distance_sample;
			sel_q    <= sensor_select;
		end
		if (cmd.diff) begin
			lvl_new_q <= level;
			slp_new_q <= slope;
			crv_new_q <= curv;
		end
		if (cmd.div_abs) begin
			neg_q <= sum_pick[SUM_W-1];
			mag_q <= sum_pick[SUM_W-1] ? SUM_W'(-sum_pick) : SUM_W'(sum_pick);
		end
		if (cmd.div_mul) prod_q <= (2*SUM_W)'(mag_q) * (2*SUM_W)'(RECIP);
		if (cmd.div_back) begin
			q0_q <= q0;
			qd_q <= SUM_W'(q0 * DEPTH_V);
		end
		if (cmd.div_fix) begin
			case (cmd.line)
				dmad_pkg::LINE_SLOPE: mean_slp_q <= LW'(res);
				dmad_pkg::LINE_CURV:  mean_crv_q <= CW'(res);
				default:              mean_lvl_q <= SW'(res);
			endcase
		end
		if (cmd.load_out) begin
			echo_q <= sel_q;
			if (status.sel_ok) begin
				out_lvl_q  <= lvl_new_q;
				out_mlvl_q <= mean_lvl_q;
				out_mslp_q <= mean_slp_q;
				out_mcrv_q <= mean_crv_q;
			end else begin
				out_lvl_q  <= '0;
				out_mlvl_q <= '0;
				out_mslp_q <= '0;
				out_mcrv_q <= '0;
			end
		end
	end

	assign sensor_echo    = echo_q;
	assign newest_level   = out_lvl_q;
	assign mean_level     = out_mlvl_q;
	assign mean_slope     = out_mslp_q;
	assign mean_curvature = out_mcrv_q;

endmodule

[hw/rtl/distance_moving_average_derivs.sv]
// Moving average of distance, slope and curvature for a set of ranging sensors.
// Input channel (in_valid/in_ready) carries distance_sample and sensor_select;
// the sample is clamped to the ceiling and pushed into that sensor's level,
// slope and curvature lines, which live in one memory each.
// Output channel (out_valid/out_ready) returns one transaction per input:
// sensor_echo, newest_level and the three truncated means.
// Config channel (cfg_valid/cfg_ready/cfg_data) writes distance_ceiling; it is
// always ready. The user must write distance_ceiling only while the block is
// idle; the block itself does not enforce this. An in-range item passes one
// memory read, one write-back, then a shared reciprocal-multiply divider
// (abs, multiply, back-multiply and fix steps) for each of the three running
// sums; an out-of-range item goes straight to the output stage.
// Reset: the ceiling returns to 4000, sums and pointers clear, and a clearing
// pass writes zero to SENSOR_COUNT * HISTORY_DEPTH memory entries, one a cycle,
// with in_ready low.
// Stall: a result waiting in the output register does not block the next
// input; the following result holds in the datapath until out_ready frees it.
module distance_moving_average_derivs #(
	parameter int HISTORY_DEPTH = dmad_pkg::HISTORY_DEPTH_DEF,
	parameter int SENSOR_COUNT  = dmad_pkg::SENSOR_COUNT_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic        [dmad_pkg::SAMPLE_W-1:0] distance_sample,
	input  logic        [dmad_pkg::SEL_W-1:0]    sensor_select,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic        [dmad_pkg::SEL_W-1:0]    sensor_echo,
	output logic        [dmad_pkg::SAMPLE_W-1:0] newest_level,
	output logic        [dmad_pkg::SAMPLE_W-1:0] mean_level,
	output logic signed [dmad_pkg::SLOPE_W-1:0]  mean_slope,
	output logic signed [dmad_pkg::CURV_W-1:0]   mean_curvature,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic        [dmad_pkg::SAMPLE_W-1:0] cfg_data
);

	dmad_pkg::cmd_t    cmd;
	dmad_pkg::status_t status;

	assign cfg_ready = 1'b1;

	dmad_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.out_ready (out_ready),
		.status    (status),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.cmd       (cmd)
	);

	dmad_dp #(
		.HISTORY_DEPTH (HISTORY_DEPTH),
		.SENSOR_COUNT  (SENSOR_COUNT)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.cfg_we          (cfg_valid && cfg_ready),
		.cfg_data        (cfg_data),
		.distance_sample (distance_sample),
		.sensor_select   (sensor_select),
		.status          (status),
		.sensor_echo     (sensor_echo),
		.newest_level    (newest_level),
		.mean_level      (mean_level),
		.mean_slope      (mean_slope),
		.mean_curvature  (mean_curvature)
	);

`include "distance_moving_average_derivs_assert.svh"

	`DMAD_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "accepted while busy")
	`DMAD_ASSERT_NOW(a_load_into_free, cmd.load_out, !out_valid || out_ready, "output overwritten")
	`DMAD_ASSERT_NOW(a_no_accept_in_clear, cmd.clear_step, !in_ready && !cmd.update, "clear overlap")

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;

	localparam int DEPTH         = dmad_pkg::HISTORY_DEPTH_DEF;
	localparam int SENSORS       = dmad_pkg::SENSOR_COUNT_DEF;
	localparam int SAMPLE_W      = dmad_pkg::SAMPLE_W;
	localparam int SEL_W         = dmad_pkg::SEL_W;
	localparam int SLOPE_W       = dmad_pkg::SLOPE_W;
	localparam int CURV_W        = dmad_pkg::CURV_W;
	localparam int SETTLE_CYCLES = 20;
	localparam int STALL_LIMIT   = 2000;
	localparam int PHASE_ITEMS   = 375;

	typedef struct packed {
		logic        [SEL_W-1:0]    echo;
		logic        [SAMPLE_W-1:0] level;
		logic        [SAMPLE_W-1:0] avg_level;
		logic signed [SLOPE_W-1:0]  avg_slope;
		logic signed [CURV_W-1:0]   avg_curv;
	} means_t;

	logic                       clk;
	logic                       arst_n          = 1'b0;
	logic                       in_valid        = 1'b0;
	logic                       in_ready;
	logic        [SAMPLE_W-1:0] distance_sample = '0;
	logic        [SEL_W-1:0]    sensor_select   = '0;
	logic                       out_valid;
	logic                       out_ready       = 1'b0;
	logic        [SEL_W-1:0]    sensor_echo;
	logic        [SAMPLE_W-1:0] newest_level;
	logic        [SAMPLE_W-1:0] mean_level;
	logic signed [SLOPE_W-1:0]  mean_slope;
	logic signed [CURV_W-1:0]   mean_curvature;
	logic                       cfg_valid       = 1'b0;
	logic                       cfg_ready;
	logic        [SAMPLE_W-1:0] cfg_data        = '0;

	distance_moving_average_derivs uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.distance_sample(distance_sample),
		.sensor_select  (sensor_select),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.sensor_echo    (sensor_echo),
		.newest_level   (newest_level),
		.mean_level     (mean_level),
		.mean_slope     (mean_slope),
		.mean_curvature (mean_curvature),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data)
	);

	logic [SAMPLE_W-1:0] ceiling = dmad_pkg::CEILING_RESET;
	int                  hist [3][SENSORS][DEPTH];
	means_t              pending_means[$];
	int                  mismatches    = 0;
	int                  send_idle_pct = 0;
	int                  recv_idle_pct = 0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic longint shift_and_average(input dmad_pkg::line_t ln, input int sel,
			input int fresh);
		longint sum;
		sum = 0;
		for (int i = DEPTH - 1; i > 0; i--) begin
			hist[ln][sel][i] = hist[ln][sel][i - 1];
			sum += hist[ln][sel][i];
		end
		hist[ln][sel][0] = fresh;
		sum += fresh;
		return sum / DEPTH;
	endfunction

	function automatic means_t predict_means(input logic [SAMPLE_W-1:0] s,
			input logic [SEL_W-1:0] sel);
		means_t r;
		int     lvl;
		int     slp;
		int     crv;
		longint ml;
		longint ms;
		longint mc;
		r = '0;
		r.echo = sel;
		if (sel < SENSORS) begin
			lvl = int'((s < ceiling) ? s : ceiling);
			ml = shift_and_average(dmad_pkg::LINE_LEVEL, int'(sel), lvl);
			slp = hist[dmad_pkg::LINE_LEVEL][sel][0] - hist[dmad_pkg::LINE_LEVEL][sel][1];
			ms = shift_and_average(dmad_pkg::LINE_SLOPE, int'(sel), slp);
			crv = hist[dmad_pkg::LINE_SLOPE][sel][0] - hist[dmad_pkg::LINE_SLOPE][sel][1];
			mc = shift_and_average(dmad_pkg::LINE_CURV, int'(sel), crv);
			r.level = lvl[SAMPLE_W-1:0];
			r.avg_level = ml[SAMPLE_W-1:0];
			r.avg_slope = ms[SLOPE_W-1:0];
			r.avg_curv = mc[CURV_W-1:0];
		end
		return r;
	endfunction

	function automatic logic [SAMPLE_W-1:0] pick_sample();
		int v;
		case ($urandom_range(4))
			0: begin
				v = int'(ceiling) - 8 + int'($urandom_range(16));
				if (v < 0) v = 0;
				if (v > 65535) v = 65535;
			end
			1: v = $urandom_range(255);
			2: v = $urandom_range(1) ? 65535 : 0;
			default: v = $urandom_range(65535);
		endcase
		return v[SAMPLE_W-1:0];
	endfunction

	function automatic logic [SEL_W-1:0] pick_sensor();
		if ($urandom_range(9) == 0) return 2'd3;
		return SEL_W'($urandom_range(SENSORS - 1));
	endfunction

	task automatic flag_mismatch(input string why, input means_t want, input means_t got);
		mismatches++;
		if (mismatches <= 10) begin
			$display("mismatch (%s): expected echo=%0d level=%0d mean=%0d slope=%0d curv=%0d",
				why, want.echo, want.level, want.avg_level, want.avg_slope, want.avg_curv);
			$display("  got echo=%0d level=%0d mean=%0d slope=%0d curv=%0d",
				got.echo, got.level, got.avg_level, got.avg_slope, got.avg_curv);
		end
	endtask

	always @(negedge clk) out_ready <= ($urandom_range(99) >= recv_idle_pct);

	always @(posedge clk) begin : check_means
		means_t got;
		means_t want;
		if (arst_n && out_valid && out_ready) begin
			got.echo = sensor_echo;
			got.level = newest_level;
			got.avg_level = mean_level;
			got.avg_slope = mean_slope;
			got.avg_curv = mean_curvature;
			if (pending_means.size() == 0) begin
				flag_mismatch("unexpected transaction", '0, got);
			end else begin
				want = pending_means.pop_front();
				if (got.echo !== want.echo || got.level !== want.level ||
						got.avg_level !== want.avg_level || got.avg_slope !== want.avg_slope ||
						got.avg_curv !== want.avg_curv)
					flag_mismatch("field", want, got);
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("FAIL distance_moving_average_derivs");
		$finish;
	end

	task automatic push_sample(input logic [SAMPLE_W-1:0] s, input logic [SEL_W-1:0] sel);
		while ($urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		distance_sample <= s;
		sensor_select <= sel;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		pending_means.push_back(predict_means(s, sel));
	endtask

	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_means.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_ceiling(input logic [SAMPLE_W-1:0] v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		ceiling = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic apply_reset();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic test_default_clamp();
		push_sample(16'd0, 2'd0);
		push_sample(16'hFFFF, 2'd0);
		push_sample(16'd3999, 2'd1);
		push_sample(16'd4000, 2'd1);
		push_sample(16'd4001, 2'd1);
		push_sample(16'd4000, 2'd2);
		push_sample(16'd0, 2'd2);
		push_sample(16'hFFFF, 2'd3);
		push_sample(16'd0, 2'd3);
	endtask

	task automatic test_ceiling_extremes();
		wait_drained();
		write_ceiling(16'hFFFF);
		push_sample(16'hFFFF, 2'd2);
		push_sample(16'd0, 2'd2);
		push_sample(16'hFFFF, 2'd2);
		push_sample(16'd0, 2'd2);
		push_sample(16'hFFFF, 2'd2);
		push_sample(16'hFFFF, 2'd0);
		push_sample(16'hAAAA, 2'd1);
		wait_drained();
		write_ceiling(16'd0);
		push_sample(16'h5555, 2'd1);
		push_sample(16'hFFFF, 2'd0);
		push_sample(16'd0, 2'd2);
		push_sample(16'hFFFF, 2'd3);
	endtask

	task automatic test_random_traffic(input int s_idle, input int r_idle,
			input logic [SAMPLE_W-1:0] first_ceiling, input logic [SAMPLE_W-1:0] second_ceiling);
		send_idle_pct = s_idle;
		recv_idle_pct = r_idle;
		wait_drained();
		write_ceiling(first_ceiling);
		for (int i = 0; i < PHASE_ITEMS / 2; i++) push_sample(pick_sample(), pick_sensor());
		wait_drained();
		write_ceiling(second_ceiling);
		for (int i = PHASE_ITEMS / 2; i < PHASE_ITEMS; i++)
			push_sample(pick_sample(), pick_sensor());
	endtask

	initial begin
		for (int l = 0; l < 3; l++)
			for (int s = 0; s < SENSORS; s++)
				for (int d = 0; d < DEPTH; d++) hist[l][s][d] = 0;
		apply_reset();
		test_default_clamp();
		test_ceiling_extremes();
		test_random_traffic(10, 48, SAMPLE_W'($urandom_range(65535)),
			SAMPLE_W'($urandom_range(8000)));
		test_random_traffic(48, 10, 16'hFFFF, SAMPLE_W'($urandom_range(65535)));
		test_random_traffic(0, 0, SAMPLE_W'($urandom_range(300)),
			SAMPLE_W'($urandom_range(65535)));
		wait_drained();
		if (mismatches == 0 && pending_means.size() == 0)
			$display("PASS distance_moving_average_derivs");
		else
			$display("FAIL distance_moving_average_derivs");
		$finish;
	end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/dmad_pkg.sv
hw/rtl/dmad_ctrl.sv
hw/rtl/dmad_dp.sv
hw/rtl/distance_moving_average_derivs.sv
tb/tb.sv
